@@ sv/sai_pkg.sv @@
`timescale 1ns / 1ps

package sai_pkg;

    localparam int DEPTH      = 64;
    localparam int KEY_W      = 64;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 7;
    localparam int POS_IN_W   = 6;
    localparam int POS_OUT_W  = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int CAP_RESET  = 64;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_dn;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

endpackage

@@ sv/sorted_array_insert_delete.sv @@
`timescale 1ns / 1ps
// Each item passes through the states S_IDLE (accept), S_CMP (compare across the
// cell row) and S_APPLY (shift the row and update the count); the result register
// is loaded as S_APPLY ends. A new item is not taken before the last one has left
// S_APPLY, and only once the result register is free or being drained.
// Reset (aresetn low, synchronous): count 0, capacity 64, key cells not cleared.
module sorted_array_insert_delete
    import sai_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: key[63:0], delete_position[69:64], zero pad[71:70]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[0]
    input  logic [0:0]            s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: inserted_position[5:0], item_count[12:6], zero pad[15:13]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: ok[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [POS_IN_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  ok_reg, ok_next;
    logic [POS_OUT_W-1:0]  ipos_reg, ipos_next;
    logic [CNT_OUT_W-1:0]  ocnt_reg, ocnt_next;

    logic [KEY_W-1:0]      cell_key [DEPTH];
    logic [DEPTH-1:0]      gt;
    logic [DEPTH-1:0]      first;
    cell_ctl_t             ctl [DEPTH];
    logic                  s_xfer;
    logic                  apply;
    logic                  ins_ok;
    logic                  del_ok;
    logic [CNT_W-1:0]      enc;
    logic [CNT_W-1:0]      ins_pos;
    logic [CNT_W-1:0]      del_pos;
    logic [31:0]           cap_lim;
    logic [31:0]           pos_wide;
    logic [31:0]           cnt_wide;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;
    assign apply    = (state_reg == S_APPLY);

    assign cap_lim = (32'(cap_reg) > DEPTH) ? DEPTH : 32'(cap_reg);
    assign ins_ok  = (mode_reg == MODE_INSERT) && (32'(count_reg) < cap_lim);
    assign del_ok  = (mode_reg == MODE_DELETE) && (32'(pos_reg) < 32'(count_reg));
    assign del_pos = CNT_W'(pos_reg);

    // lowest cell holding a key greater than the new one
    always_comb begin
        first = gt & ~{gt[DEPTH-2:0], 1'b0};
        enc   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            enc = enc | (first[i] ? CNT_W'(i) : '0);
        end
        ins_pos = (|gt) ? enc : count_reg;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_W-1:0] lower;
            logic [KEY_W-1:0] upper;
            if (g == 0) begin : g_lo0
                assign lower = '0;
            end else begin : g_lo
                assign lower = cell_key[g-1];
            end
            if (g == DEPTH - 1) begin : g_hi0
                assign upper = '0;
            end else begin : g_hi
                assign upper = cell_key[g+1];
            end
            assign ctl[g].load     = apply && ins_ok && (CNT_W'(g) == ins_pos);
            assign ctl[g].shift_up = apply && ins_ok && (CNT_W'(g) > ins_pos);
            assign ctl[g].shift_dn = apply && del_ok && (CNT_W'(g) >= del_pos);

            sai_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl[g]),
                .valid_in  (CNT_W'(g) < count_reg),
                .item_key  (key_reg),
                .lower_key (lower),
                .upper_key (upper),
                .key_out   (cell_key[g]),
                .gt_out    (gt[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        cap_next     = cap_reg;
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        ipos_next    = ipos_reg;
        ocnt_next    = ocnt_reg;
        pos_wide     = '0;
        cnt_wide     = 32'(count_reg);

        if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
            cap_next = pwdata[CAP_W-1:0];
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    mode_next  = s_tuser[0];
                    key_next   = s_tdata[KEY_W-1:0];
                    pos_next   = s_tdata[KEY_W+POS_IN_W-1:KEY_W];
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (ins_ok) begin
                    count_next = count_reg + 1'b1;
                    pos_wide   = 32'(ins_pos);
                end else if (del_ok) begin
                    count_next = count_reg - 1'b1;
                end
                cnt_wide     = 32'(count_next);
                ok_next      = ins_ok || del_ok;
                ipos_next    = pos_wide[POS_OUT_W-1:0];
                ocnt_next    = cnt_wide[CNT_OUT_W-1:0];
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_W'(CAP_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg <= mode_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        ok_reg   <= ok_next;
        ipos_reg <= ipos_next;
        ocnt_reg <= ocnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = M_TDATA_W'({ocnt_reg, ipos_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("count above depth");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply && ins_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not bump count");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        apply |=> (m_valid_reg && (m_tuser[0] == $past(ins_ok || del_ok))))
        else $error("result missing after apply");

endmodule

@@ sv/sai_cell.sv @@
`timescale 1ns / 1ps

module sai_cell
    import sai_pkg::*;
(
    input  logic             aclk,
    input  cell_ctl_t        ctl,
    input  logic             valid_in,
    input  logic [KEY_W-1:0] item_key,
    input  logic [KEY_W-1:0] lower_key,
    input  logic [KEY_W-1:0] upper_key,
    output logic [KEY_W-1:0] key_out,
    output logic             gt_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             gt_reg;
    logic             gt_next;

    always_comb begin
        key_next = key_reg;
        if (ctl.load) begin
            key_next = item_key;
        end else if (ctl.shift_up) begin
            key_next = lower_key;
        end else if (ctl.shift_dn) begin
            key_next = upper_key;
        end
        gt_next = valid_in && (key_reg > item_key);
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        gt_reg  <= gt_next;
    end

    assign key_out = key_reg;
    assign gt_out  = gt_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sai_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT = 400;
    localparam int CALM_FROM = 800;
    localparam int CALM_TO = 1000;
    localparam int CAP_RANDOM = -1;
    localparam int N_PHASES = 8;
    localparam int PHASE_CAP [N_PHASES] = '{127, 64, 64, 0, 10, 3, CAP_RANDOM, 64};
    localparam int PHASE_INS_PCT [N_PHASES] = '{85, 50, 10, 50, 70, 40, 60, 70};
    localparam int PHASE_ITEMS [N_PHASES] = '{250, 250, 100, 100, 200, 150, 200, 150};

    typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        mode;
        logic [63:0] key;
        logic [5:0]  pos;
        logic        typed;
        logic        ok;
        logic [5:0]  at;
        logic [6:0]  count;
    } op_row_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] at;
        logic [6:0] count;
    } list_outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // typed expectation travelling with the current transfer
    logic                  row_typed = 1'b0;
    list_outcome_t         row_want = '0;

    logic [63:0]   model_keys [DEPTH];
    int            model_count = 0;
    logic [6:0]    model_cap = 7'(CAP_RESET);
    list_outcome_t outcome_q [$];
    int            items_in = 0;
    int            mismatches = 0;
    int            idle_cycles = 0;
    logic          hold_done = 1'b0;
    logic          calm;
    op_row_t       plan [28];

    assign calm = (items_in >= CALM_FROM) && (items_in < CALM_TO);

    sorted_array_insert_delete uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic list_outcome_t apply_list_op(logic mode, logic [63:0] key,
                                                    logic [5:0] pos);
        list_outcome_t r;
        int limit;
        int slot;
        int i;
        r = '0;
        limit = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
        if (mode == MODE_INSERT) begin
            if (model_count < limit) begin
                slot = model_count;
                while (slot > 0 && model_keys[slot-1] > key) begin
                    model_keys[slot] = model_keys[slot-1];
                    slot--;
                end
                model_keys[slot] = key;
                model_count++;
                r.ok = 1'b1;
                r.at = slot[5:0];
            end
        end else if (int'(pos) < model_count) begin
            for (i = int'(pos) + 1; i < model_count; i++)
                model_keys[i-1] = model_keys[i];
            model_count--;
            r.ok = 1'b1;
        end
        r.count = model_count[6:0];
        return r;
    endfunction

    // predictor, scoreboard and watchdog, all sampled at the rising edge
    always @(posedge aclk) begin
        list_outcome_t want;
        list_outcome_t got;
        logic active;
        active = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            active = 1'b1;
            want = apply_list_op(s_tuser[0], s_tdata[63:0], s_tdata[69:64]);
            outcome_q.push_back(row_typed ? row_want : want);
            items_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            active = 1'b1;
            got.ok = m_tuser[0];
            got.at = m_tdata[5:0];
            got.count = m_tdata[12:6];
            if (outcome_q.size() == 0) begin
                $display("%0t: result transfer with none expected: ok %0d at %0d count %0d",
                         $time, got.ok, got.at, got.count);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                if (got.ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
                    mismatches++;
                end
                if (got.at !== want.at) begin
                    $display("%0t: inserted_position expected %0d actual %0d",
                             $time, want.at, got.at);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: item_count expected %0d actual %0d",
                             $time, want.count, got.count);
                    mismatches++;
                end
            end
        end
        if (aresetn && psel && penable && pwrite && pready) begin
            active = 1'b1;
            if (paddr == ADDR_CAPACITY)
                model_cap = pwdata[CAP_W-1:0];
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random backpressure, one long hold-off, a calm stretch
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && items_in >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic send_op(logic mode, logic [63:0] key, logic [5:0] pos, logic typed,
                           list_outcome_t want);
        while (!calm && $urandom_range(99) < 15) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {2'b00, pos, key};
        row_typed <= typed;
        row_want <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic set_capacity(int value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        pwdata <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_op(int insert_pct);
        logic mode;
        logic [63:0] key;
        logic [5:0] pos;
        int sel;
        mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
        sel = $urandom_range(9);
        if (sel < 2)
            key = 64'($urandom_range(15));
        else if (sel == 2)
            key = '0;
        else if (sel == 3)
            key = '1;
        else
            key = {$urandom, $urandom};
        if (model_count > 0 && $urandom_range(99) < 85)
            pos = 6'($urandom_range(model_count - 1));
        else
            pos = 6'($urandom);
        send_op(mode, key, pos, 1'b0, '0);
    endtask

    initial begin
        list_outcome_t want;
        int p;
        int n;
        plan = '{
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd63, 1'b1, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'h0,                   6'd0,  1'b1, 1'b1, 6'd0, 7'd1},
            '{ROW_OP, MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b1, 1'b1, 6'd1, 7'd2},
            '{ROW_OP, MODE_INSERT, 64'h0,                   6'd0,  1'b1, 1'b1, 6'd1, 7'd3},
            '{ROW_OP, MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b1, 1'b1, 6'd3, 7'd4},
            '{ROW_OP, MODE_INSERT, 64'h8000_0000_0000_0000, 6'd0,  1'b1, 1'b1, 6'd2, 7'd5},
            '{ROW_OP, MODE_INSERT, 64'h8000_0000_0000_0000, 6'd0,  1'b1, 1'b1, 6'd3, 7'd6},
            '{ROW_OP, MODE_INSERT, 64'h1,                   6'd0,  1'b1, 1'b1, 6'd2, 7'd7},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd7,  1'b1, 1'b0, 6'd0, 7'd7},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd6,  1'b1, 1'b1, 6'd0, 7'd6},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd0,  1'b1, 1'b1, 6'd0, 7'd5},
            '{ROW_OP, MODE_INSERT, 64'h5,                   6'd63, 1'b1, 1'b1, 6'd2, 7'd6},
            '{ROW_OP, MODE_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd2,  1'b1, 1'b1, 6'd0, 7'd5},
            '{ROW_OP, MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 6'd0,  1'b1, 1'b1, 6'd4, 7'd6},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd63, 1'b1, 1'b0, 6'd0, 7'd6},
            '{ROW_OP, MODE_INSERT, 64'h0123_4567_89AB_CDEF, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'hFEDC_BA98_7654_3210, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd1,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'h5555_5555_5555_5555, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            // capacity dropped below the count: inserts refused, deletes still work
            '{ROW_CAP, MODE_INSERT, 64'd2,                  6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'h7,                   6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_DELETE, 64'h0,                   6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_CAP, MODE_INSERT, 64'd0,                  6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'h0,                   6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            // capacity above depth acts as depth
            '{ROW_CAP, MODE_INSERT, 64'd127,                6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{ROW_OP, MODE_INSERT, 64'd42,                  6'd0,  1'b0, 1'b0, 6'd0, 7'd0}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CAP) begin
                set_capacity(int'(plan[i].key));
            end else begin
                want.ok = plan[i].ok;
                want.at = plan[i].at;
                want.count = plan[i].count;
                send_op(plan[i].mode, plan[i].key, plan[i].pos, plan[i].typed, want);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            set_capacity(PHASE_CAP[p] == CAP_RANDOM ? int'($urandom_range(63, 1))
                                                    : PHASE_CAP[p]);
            for (n = 0; n < PHASE_ITEMS[p]; n++)
                random_op(PHASE_INS_PCT[p]);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
